// ===== hw/rtl/svpt_pkg.sv =====
// shared constants, types and helpers for the sextic via-point trajectory block
// no dependencies
package svpt_pkg;

  localparam int POS_WIDTH_DEF   = 16;
  localparam int PHASE_FRAC_DEF  = 16;
  localparam int TIME_W          = 16;
  localparam int PT_W            = 48;
  localparam int CFG_IDX_W       = 2;
  localparam logic [15:0] DURATION_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_VIA   = 2'd1,
    REG_END   = 2'd2,
    REG_DUR   = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/sextic_via_point_trajectory_top.sv =====
// sextic via-point trajectory: divider cell chain, then horner cell chain
// depends on svpt_pkg, svpt_div_cell, svpt_horner_cell
// stages: TIME_W+PHASE_FRAC_BITS division cells, 6 horner cells and 1 output
// register
// throughput: one transfer per cycle unless stalled; the whole chain advances
// when the output register is free or being taken, else in_stall is raised
// reset: synchronous active low, points clear to 0 and duration to 1000
module sextic_via_point_trajectory_top #(
  parameter int POS_WIDTH       = svpt_pkg::POS_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = svpt_pkg::PHASE_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [svpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svpt_pkg::PT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [svpt_pkg::TIME_W-1:0]   in_time_ticks,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [POS_WIDTH-1:0]   out_pos_x,
  output logic signed [POS_WIDTH-1:0]   out_pos_y,
  output logic signed [POS_WIDTH-1:0]   out_pos_z
);
  import svpt_pkg::*;

  // quotient bits needed: integer bit plus fraction
  localparam int UW = PHASE_FRAC_BITS + 1;
  // numerator is t << F, so bits = TIME_W + F; one cell per bit
  localparam int NDIV = TIME_W + PHASE_FRAC_BITS;
  localparam int QW = NDIV;
  localparam int AW = POS_WIDTH + 12;
  // packed points widened so that field bits above the register read as zero
  localparam int PKW = (3*POS_WIDTH > PT_W) ? 3*POS_WIDTH : PT_W;

  logic [PT_W-1:0]   start_r, via_r, end_r;
  logic [TIME_W-1:0] dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      via_r <= '0;
      end_r <= '0;
      dur_r <= DURATION_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START: start_r <= cfg_data;
        REG_VIA:   via_r <= cfg_data;
        REG_END:   end_r <= cfg_data;
        REG_DUR:   dur_r <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PKW-1:0] start_w, via_w, end_w;
  assign start_w = PKW'(start_r);
  assign via_w = PKW'(via_r);
  assign end_w = PKW'(end_r);

  // field extraction and coefficients, constant between config writes
  logic signed [AW-1:0] s0 [3], a3 [3], a4 [3], a5 [3], a6 [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [POS_WIDTH-1:0] fs, fv, fe;
      logic signed [AW-1:0] d1, d2;
      fs = start_w[a*POS_WIDTH +: POS_WIDTH];
      fv = via_w[a*POS_WIDTH +: POS_WIDTH];
      fe = end_w[a*POS_WIDTH +: POS_WIDTH];
      s0[a] = AW'(fs);
      d1 = AW'(fv) - s0[a];
      d2 = AW'(fe) - s0[a];
      a3[a] = AW'(64)*d1 - AW'(22)*d2;
      a4[a] = AW'(81)*d2 - AW'(192)*d1;
      a5[a] = AW'(192)*d1 - AW'(90)*d2;
      a6[a] = AW'(32)*d2 - AW'(64)*d1;
    end
  end

  logic adv;
  logic out_v_r;
  assign adv = !out_v_r || !out_stall;
  assign in_stall = !adv;

  // clamp time, zero duration gives phase 0
  logic [TIME_W-1:0] t_cl;
  logic              dz;
  assign dz = (dur_r == '0);
  assign t_cl = dz ? '0 : ((in_time_ticks > dur_r) ? dur_r : in_time_ticks);

  logic              dv [NDIV+1];
  logic [TIME_W:0]   drem [NDIV+1];
  logic [TIME_W-1:0] dnum [NDIV+1], dden [NDIV+1];
  logic [QW-1:0]     dq [NDIV+1];

  assign dv[0] = in_valid;
  assign drem[0] = '0;
  assign dnum[0] = t_cl;
  assign dden[0] = dz ? TIME_W'(1) : dur_r;
  assign dq[0] = '0;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    svpt_div_cell #(.QW(QW)) u_cell (
      .clk, .rst_n, .adv,
      .v_in(dv[i]), .rem_in(drem[i]), .num_in(dnum[i]), .den_in(dden[i]),
      .q_in(dq[i]),
      .v_out(dv[i+1]), .rem_out(drem[i+1]), .num_out(dnum[i+1]),
      .den_out(dden[i+1]), .q_out(dq[i+1])
    );
  end

  // horner chain: seed is a6, cells add a5,a4,a3,0,0,0 and the last adds 0
  localparam int NH = 6;
  logic                 hv [NH+1];
  logic [UW-1:0]        hu [NH+1];
  logic signed [AW-1:0] hacc [NH+1][3];
  logic signed [AW-1:0] hbase [NH+1][3];
  logic signed [AW-1:0] hadd [NH][3];

  assign hv[0] = dv[NDIV];
  assign hu[0] = dq[NDIV][UW-1:0];
  assign hacc[0] = a6;
  assign hbase[0] = s0;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hadd[0][a] = a5[a];
      hadd[1][a] = a4[a];
      hadd[2][a] = a3[a];
      hadd[3][a] = '0;
      hadd[4][a] = '0;
      hadd[5][a] = '0;
    end
  end

  for (genvar k = 0; k < NH; k++) begin : g_horner
    svpt_horner_cell #(.AW(AW), .UW(UW), .F(PHASE_FRAC_BITS)) u_cell (
      .clk, .rst_n, .adv,
      .v_in(hv[k]), .u_in(hu[k]), .acc_in(hacc[k]), .add_in(hadd[k]),
      .base_in(hbase[k]),
      .v_out(hv[k+1]), .u_out(hu[k+1]), .acc_out(hacc[k+1]),
      .base_out(hbase[k+1])
    );
  end

  // add start point, saturate, register output
  localparam logic signed [AW-1:0] PMAX = AW'((1 <<< (POS_WIDTH-1)) - 1);
  localparam logic signed [AW-1:0] PMIN = -PMAX - AW'(1);
  logic signed [POS_WIDTH-1:0] sat [3];
  logic signed [POS_WIDTH-1:0] pos_r [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [AW-1:0] sum;
      sum = hbase[NH][a] + hacc[NH][a];
      if (sum > PMAX) sat[a] = PMAX[POS_WIDTH-1:0];
      else if (sum < PMIN) sat[a] = PMIN[POS_WIDTH-1:0];
      else sat[a] = sum[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= hv[NH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= sat;
    end
  end

  assign out_valid = out_v_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
endmodule

// ===== hw/rtl/svpt_div_cell.sv =====
// one restoring-division cell: produces one quotient bit per cycle of pipeline, holding while adv is low
// depends on svpt_pkg
module svpt_div_cell #(
  parameter int QW = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       v_in,
  input  logic [svpt_pkg::TIME_W:0]  rem_in,
  input  logic [svpt_pkg::TIME_W-1:0] num_in,
  input  logic [svpt_pkg::TIME_W-1:0] den_in,
  input  logic [QW-1:0]              q_in,
  output logic                       v_out,
  output logic [svpt_pkg::TIME_W:0]  rem_out,
  output logic [svpt_pkg::TIME_W-1:0] num_out,
  output logic [svpt_pkg::TIME_W-1:0] den_out,
  output logic [QW-1:0]              q_out
);
  import svpt_pkg::*;

  logic [TIME_W+1:0] trial;
  logic [TIME_W:0]   rem_nxt;
  logic              bit_nxt;
  logic              v_r;
  logic [TIME_W:0]   rem_r;
  logic [TIME_W-1:0] num_r, den_r;
  logic [QW-1:0]     q_r;

  // shift in next numerator bit (msb first), subtract if it fits
  always_comb begin
    trial = {rem_in, num_in[TIME_W-1]};
    bit_nxt = (trial >= {2'b00, den_in});
    rem_nxt = bit_nxt ? (TIME_W+1)'(trial - {2'b00, den_in}) : trial[TIME_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      num_r <= {num_in[TIME_W-2:0], 1'b0};
      den_r <= den_in;
      q_r   <= {q_in[QW-2:0], bit_nxt};
    end
  end

  assign v_out = v_r;
  assign rem_out = rem_r;
  assign num_out = num_r;
  assign den_out = den_r;
  assign q_out = q_r;
endmodule

// ===== hw/rtl/svpt_horner_cell.sv =====
// one horner step for three axes: acc = add + floor(acc * u / 2^F)
// depends on svpt_pkg
module svpt_horner_cell #(
  parameter int AW = 32,
  parameter int UW = 17,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 v_in,
  input  logic [UW-1:0]        u_in,
  input  logic signed [AW-1:0] acc_in [3],
  input  logic signed [AW-1:0] add_in [3],
  input  logic signed [AW-1:0] base_in [3],
  output logic                 v_out,
  output logic [UW-1:0]        u_out,
  output logic signed [AW-1:0] acc_out [3],
  output logic signed [AW-1:0] base_out [3]
);
  import svpt_pkg::*;

  logic signed [AW+UW:0]   prod [3];
  logic signed [AW-1:0]    acc_nxt [3];
  logic                    v_r;
  logic [UW-1:0]           u_r;
  logic signed [AW-1:0]    acc_r [3];
  logic signed [AW-1:0]    base_r [3];

  // arithmetic shift of the product is the floor division
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = (AW+UW+1)'(acc_in[a]) * $signed({1'b0, u_in});
      acc_nxt[a] = AW'(prod[a] >>> F) + add_in[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= u_in;
      acc_r <= acc_nxt;
      base_r <= base_in;
    end
  end

  assign v_out = v_r;
  assign u_out = u_r;
  assign acc_out = acc_r;
  assign base_out = base_r;
endmodule
